// ===== sv/tlc_pkg.sv =====
package tlc_pkg;

  localparam int unsigned SecWidth   = 7;
  localparam int unsigned DigitWidth = 4;
  localparam int unsigned LampWidth  = 6;
  localparam int unsigned AddrWidth  = 4;
  localparam int unsigned DataWidth  = 32;

  localparam logic [SecWidth-1:0] MAX_SECONDS = 7'd99;
  localparam logic [SecWidth-1:0] RESET_RED    = 7'd5;
  localparam logic [SecWidth-1:0] RESET_YELLOW = 7'd2;
  localparam logic [SecWidth-1:0] RESET_GREEN  = 7'd3;

  localparam logic [AddrWidth-1:0] ADDR_RED    = 4'h0;
  localparam logic [AddrWidth-1:0] ADDR_YELLOW = 4'h4;
  localparam logic [AddrWidth-1:0] ADDR_GREEN  = 4'h8;

  localparam logic OP_SECOND = 1'b0;
  localparam logic OP_SCAN   = 1'b1;

  localparam logic [1:0] MODE_NORMAL = 2'd0;
  localparam logic [1:0] MODE_RED    = 2'd1;
  localparam logic [1:0] MODE_YELLOW = 2'd2;
  localparam logic [1:0] MODE_GREEN  = 2'd3;

  localparam logic [LampWidth-1:0] LAMP_RED_A = 6'h01;
  localparam logic [LampWidth-1:0] LAMP_YEL_A = 6'h02;
  localparam logic [LampWidth-1:0] LAMP_GRN_A = 6'h04;
  localparam logic [LampWidth-1:0] LAMP_RED_B = 6'h08;
  localparam logic [LampWidth-1:0] LAMP_YEL_B = 6'h10;
  localparam logic [LampWidth-1:0] LAMP_GRN_B = 6'h20;

  localparam logic [1:0] SCAN_A_TENS  = 2'd0;
  localparam logic [1:0] SCAN_A_UNITS = 2'd1;
  localparam logic [1:0] SCAN_B_TENS  = 2'd2;
  localparam logic [1:0] SCAN_B_UNITS = 2'd3;

  typedef enum logic [1:0] {
    PH_REDA_GRNB = 2'd0,
    PH_REDA_YELB = 2'd1,
    PH_GRNA_REDB = 2'd2,
    PH_YELA_REDB = 2'd3
  } phase_t;

  typedef struct packed {
    logic       operation;
    logic [1:0] mode;
  } req_t;

  typedef struct packed {
    logic [SecWidth-1:0] red;
    logic [SecWidth-1:0] yellow;
    logic [SecWidth-1:0] green;
  } dur_t;

  // tens = floor(v * 205 / 2048), exact for every 7-bit value
  function automatic logic [DigitWidth-1:0] tens_of(input logic [SecWidth-1:0] v);
    logic [14:0] prod;
    prod = 15'(v) * 15'd205;
    return prod[14:11];
  endfunction

  function automatic logic [DigitWidth-1:0] units_of(input logic [SecWidth-1:0] v);
    logic [SecWidth-1:0] t10;
    logic [SecWidth-1:0] diff;
    t10  = SecWidth'({3'b000, tens_of(v)} * 7'd10);
    diff = v - t10;
    return diff[DigitWidth-1:0];
  endfunction

  function automatic logic [SecWidth-1:0] clamp_sec(input logic [SecWidth-1:0] v);
    return (v > MAX_SECONDS) ? MAX_SECONDS : v;
  endfunction

endpackage

// ===== sv/tlc_in_if.sv =====
interface tlc_in_if;
  logic       valid;
  logic       ready;
  logic       operation;
  logic [1:0] mode;

  modport source (output valid, output operation, output mode, input ready);
  modport sink   (input valid, input operation, input mode, output ready);
endinterface

// ===== sv/tlc_out_if.sv =====
interface tlc_out_if;
  logic                                valid;
  logic                                ready;
  logic [tlc_pkg::LampWidth-1:0]       lights;
  logic [1:0]                          digit_select;
  logic [tlc_pkg::DigitWidth-1:0]      digit_value;
  logic [tlc_pkg::SecWidth-1:0]        count_a;
  logic [tlc_pkg::SecWidth-1:0]        count_b;
  logic [1:0]                          phase;

  modport source (output valid, output lights, output digit_select, output digit_value,
                  output count_a, output count_b, output phase, input ready);
  modport sink   (input valid, input lights, input digit_select, input digit_value,
                  input count_a, input count_b, input phase, output ready);
endinterface

// ===== sv/tlc_cfg_regs.sv =====
module tlc_cfg_regs (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           psel,
  input  logic                           penable,
  input  logic                           pwrite,
  input  logic [tlc_pkg::AddrWidth-1:0]  paddr,
  input  logic [tlc_pkg::DataWidth-1:0]  pwdata,
  output logic [tlc_pkg::DataWidth-1:0]  prdata,
  output logic                           pready,
  output tlc_pkg::dur_t                  dur
);

  logic [tlc_pkg::SecWidth-1:0] red_r;
  logic [tlc_pkg::SecWidth-1:0] yellow_r;
  logic [tlc_pkg::SecWidth-1:0] green_r;
  logic                         wr_en;
  logic [tlc_pkg::SecWidth-1:0] wr_val;

  assign pready = 1'b1;
  assign wr_en  = psel & penable & pwrite;
  assign wr_val = pwdata[tlc_pkg::SecWidth-1:0];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      red_r    <= tlc_pkg::RESET_RED;
      yellow_r <= tlc_pkg::RESET_YELLOW;
      green_r  <= tlc_pkg::RESET_GREEN;
    end else if (wr_en) begin
      case (paddr)
        tlc_pkg::ADDR_RED:    red_r    <= wr_val;
        tlc_pkg::ADDR_YELLOW: yellow_r <= wr_val;
        tlc_pkg::ADDR_GREEN:  green_r  <= wr_val;
        default: ;
      endcase
    end
  end

  always_comb begin
    case (paddr)
      tlc_pkg::ADDR_RED:    prdata = tlc_pkg::DataWidth'(red_r);
      tlc_pkg::ADDR_YELLOW: prdata = tlc_pkg::DataWidth'(yellow_r);
      tlc_pkg::ADDR_GREEN:  prdata = tlc_pkg::DataWidth'(green_r);
      default:              prdata = '0;
    endcase
  end

  assign dur.red    = tlc_pkg::clamp_sec(red_r);
  assign dur.yellow = tlc_pkg::clamp_sec(yellow_r);
  assign dur.green  = tlc_pkg::clamp_sec(green_r);

endmodule

// ===== sv/tlc_in_stage.sv =====
module tlc_in_stage (
  input  logic           clk,
  input  logic           rst_n,
  tlc_in_if.sink         in_if,
  output logic           req_valid,
  output tlc_pkg::req_t  req,
  input  logic           req_ready
);

  logic          valid_r;
  tlc_pkg::req_t req_r;

  assign in_if.ready = !valid_r || req_ready;
  assign req_valid   = valid_r;
  assign req         = req_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (in_if.ready) begin
      valid_r <= in_if.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_if.ready && in_if.valid) begin
      req_r.operation <= in_if.operation;
      req_r.mode      <= in_if.mode;
    end
  end

endmodule

// ===== sv/tlc_core.sv =====
module tlc_core (
  input  logic           clk,
  input  logic           rst_n,
  input  tlc_pkg::dur_t  dur,
  input  logic           req_valid,
  input  tlc_pkg::req_t  req,
  output logic           req_ready,
  tlc_out_if.source      out_if
);

  logic                              out_valid_r;
  tlc_pkg::phase_t                   phase_r, phase_nxt, phase_step;
  logic [tlc_pkg::SecWidth-1:0]      cnt_a_r, cnt_a_nxt, load_a;
  logic [tlc_pkg::SecWidth-1:0]      cnt_b_r, cnt_b_nxt, load_b;
  logic [1:0]                        scan_r, scan_nxt;
  logic [tlc_pkg::LampWidth-1:0]     lamps_r, lamps_nxt, load_lamps, blink_mask;
  logic [tlc_pkg::DigitWidth-1:0]    digit_r, digit_nxt;
  logic [tlc_pkg::SecWidth-1:0]      first_val, second_val, mod_dur;
  logic                              take;
  logic                              normal_sec;
  logic                              advance;

  assign req_ready  = !out_valid_r || out_if.ready;
  assign take       = req_valid && req_ready;
  assign normal_sec = (req.operation == tlc_pkg::OP_SECOND)
                   && (req.mode == tlc_pkg::MODE_NORMAL);
  assign advance    = normal_sec && ((cnt_a_r == '0) || (cnt_b_r == '0));

  // next phase
  always_comb begin
    phase_step = tlc_pkg::phase_t'(phase_r + 2'd1);
    phase_nxt  = advance ? phase_step : phase_r;
  end

  // loads and lamp patterns of the entered phase
  always_comb begin
    load_a     = cnt_a_r;
    load_b     = cnt_b_r;
    load_lamps = lamps_r;
    case (phase_step)
      tlc_pkg::PH_REDA_GRNB: begin
        load_lamps = tlc_pkg::LAMP_RED_A | tlc_pkg::LAMP_GRN_B;
        load_a     = dur.red + 7'd1;
        load_b     = dur.green + 7'd1;
      end
      tlc_pkg::PH_REDA_YELB: begin
        load_lamps = tlc_pkg::LAMP_RED_A | tlc_pkg::LAMP_YEL_B;
        load_b     = dur.yellow;
      end
      tlc_pkg::PH_GRNA_REDB: begin
        load_lamps = tlc_pkg::LAMP_GRN_A | tlc_pkg::LAMP_RED_B;
        load_a     = dur.green + 7'd1;
        load_b     = dur.red + 7'd1;
      end
      tlc_pkg::PH_YELA_REDB: begin
        load_lamps = tlc_pkg::LAMP_YEL_A | tlc_pkg::LAMP_RED_B;
        load_a     = dur.yellow;
      end
      default: ;
    endcase
  end

  always_comb begin
    case (req.mode)
      tlc_pkg::MODE_RED: begin
        blink_mask = tlc_pkg::LAMP_RED_A | tlc_pkg::LAMP_RED_B;
        mod_dur    = dur.red;
      end
      tlc_pkg::MODE_YELLOW: begin
        blink_mask = tlc_pkg::LAMP_YEL_A | tlc_pkg::LAMP_YEL_B;
        mod_dur    = dur.yellow;
      end
      tlc_pkg::MODE_GREEN: begin
        blink_mask = tlc_pkg::LAMP_GRN_A | tlc_pkg::LAMP_GRN_B;
        mod_dur    = dur.green;
      end
      default: begin
        blink_mask = '0;
        mod_dur    = '0;
      end
    endcase
  end

  // counts and lamps on a second tick
  always_comb begin
    cnt_a_nxt = cnt_a_r;
    cnt_b_nxt = cnt_b_r;
    lamps_nxt = lamps_r;
    if (req.operation == tlc_pkg::OP_SECOND) begin
      if (req.mode == tlc_pkg::MODE_NORMAL) begin
        if (advance) begin
          cnt_a_nxt = load_a;
          cnt_b_nxt = load_b;
          lamps_nxt = load_lamps;
        end
        if (cnt_a_nxt != '0) cnt_a_nxt = cnt_a_nxt - 7'd1;
        if (cnt_b_nxt != '0) cnt_b_nxt = cnt_b_nxt - 7'd1;
      end else begin
        lamps_nxt = lamps_r ^ blink_mask;
      end
    end
  end

  // display multiplex on a scan tick
  always_comb begin
    if (req.mode == tlc_pkg::MODE_NORMAL) begin
      first_val  = cnt_a_r;
      second_val = cnt_b_r;
    end else begin
      first_val  = tlc_pkg::SecWidth'(req.mode);
      second_val = mod_dur;
    end
    scan_nxt  = scan_r;
    digit_nxt = digit_r;
    if (req.operation == tlc_pkg::OP_SCAN) begin
      scan_nxt = scan_r + 2'd1;
      case (scan_nxt)
        tlc_pkg::SCAN_A_TENS:  digit_nxt = tlc_pkg::tens_of(first_val);
        tlc_pkg::SCAN_A_UNITS: digit_nxt = tlc_pkg::units_of(first_val);
        tlc_pkg::SCAN_B_TENS:  digit_nxt = tlc_pkg::tens_of(second_val);
        tlc_pkg::SCAN_B_UNITS: digit_nxt = tlc_pkg::units_of(second_val);
        default:               digit_nxt = digit_r;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
      phase_r     <= tlc_pkg::PH_YELA_REDB;
      cnt_a_r     <= '0;
      cnt_b_r     <= '0;
      scan_r      <= '0;
      lamps_r     <= '0;
      digit_r     <= '0;
    end else begin
      if (req_ready) begin
        out_valid_r <= req_valid;
      end
      if (take) begin
        phase_r <= phase_nxt;
        cnt_a_r <= cnt_a_nxt;
        cnt_b_r <= cnt_b_nxt;
        scan_r  <= scan_nxt;
        lamps_r <= lamps_nxt;
        digit_r <= digit_nxt;
      end
    end
  end

  assign out_if.valid        = out_valid_r;
  assign out_if.lights       = lamps_r;
  assign out_if.digit_select = scan_r;
  assign out_if.digit_value  = digit_r;
  assign out_if.count_a      = cnt_a_r;
  assign out_if.count_b      = cnt_b_r;
  assign out_if.phase        = phase_r;

endmodule

// ===== sv/two_way_traffic_light_countdown_top.sv =====
// channel  | direction | handshake     | payload
// in_if    | in        | valid/ready   | operation, mode
// out_if   | out       | valid/ready   | lights, digit_select, digit_value,
//          |           |               | count_a, count_b, phase
// cfg      | in        | psel/penable  | paddr, pwdata, prdata (red/yellow/green seconds)
//
// One request per cycle while out_if is not stalled: an input register, then one
// pass of logic into the state and result registers.
// Synchronous active-low reset: phase 3, counts and display cleared, lamps off,
// durations 5/2/3 seconds.
// A stalled result holds its register; the input register still takes one
// request, and further requests wait on in_if.ready.
module two_way_traffic_light_countdown_top (
  input  logic                           clk,
  input  logic                           rst_n,
  tlc_in_if.sink                         in_if,
  tlc_out_if.source                      out_if,
  input  logic                           psel,
  input  logic                           penable,
  input  logic                           pwrite,
  input  logic [tlc_pkg::AddrWidth-1:0]  paddr,
  input  logic [tlc_pkg::DataWidth-1:0]  pwdata,
  output logic [tlc_pkg::DataWidth-1:0]  prdata,
  output logic                           pready
);

  tlc_pkg::dur_t dur;
  tlc_pkg::req_t req;
  logic          req_valid;
  logic          req_ready;

  tlc_cfg_regs u_cfg (
    .clk     (clk),
    .rst_n   (rst_n),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .dur     (dur)
  );

  tlc_in_stage u_in (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_if     (in_if),
    .req_valid (req_valid),
    .req       (req),
    .req_ready (req_ready)
  );

  tlc_core u_core (
    .clk       (clk),
    .rst_n     (rst_n),
    .dur       (dur),
    .req_valid (req_valid),
    .req       (req),
    .req_ready (req_ready),
    .out_if    (out_if)
  );

endmodule

// ===== tb/sv/tb.sv =====
module tb;
  timeunit 1ns;
  timeprecision 1ps;

  import tlc_pkg::*;

  localparam int DIGIT_BASE      = 10;
  localparam int ROUNDS          = 10;
  localparam int ITEMS_PER_ROUND = 83;
  localparam int DRAIN_LIMIT     = 5000;

  typedef struct packed {
    logic [LampWidth-1:0]  lights;
    logic [1:0]            sel;
    logic [DigitWidth-1:0] value;
    logic [SecWidth-1:0]   cnt_a;
    logic [SecWidth-1:0]   cnt_b;
    phase_t                phase;
  } light_view_t;

  typedef enum logic [1:0] {
    ROW_REQ,
    ROW_REQ_KNOWN,
    ROW_CFG
  } row_kind_t;

  typedef struct packed {
    row_kind_t             kind;
    logic [AddrWidth-1:0]  addr;
    logic [SecWidth-1:0]   secs;
    logic                  op;
    logic [1:0]            mode;
    light_view_t           want;
  } script_row_t;

  localparam light_view_t NO_VIEW = '0;
  localparam logic [LampWidth-1:0] LAMPS_0 = LAMP_RED_A | LAMP_GRN_B;
  localparam logic [LampWidth-1:0] LAMPS_EDITED = LAMP_YEL_A | LAMP_GRN_A | LAMP_RED_B |
                                                  LAMP_YEL_B;

  localparam int SCRIPT_LEN = 28;
  localparam script_row_t SCRIPT [0:SCRIPT_LEN-1] = '{
    '{ROW_REQ_KNOWN, ADDR_RED, 7'd0, OP_SCAN, MODE_NORMAL,
      '{6'h00, 2'd1, 4'd0, 7'd0, 7'd0, PH_YELA_REDB}},
    '{ROW_REQ_KNOWN, ADDR_RED, 7'd0, OP_SECOND, MODE_NORMAL,
      '{LAMPS_0, 2'd1, 4'd0, 7'd5, 7'd3, PH_REDA_GRNB}},
    '{ROW_REQ_KNOWN, ADDR_RED, 7'd0, OP_SCAN, MODE_NORMAL,
      '{LAMPS_0, 2'd2, 4'd0, 7'd5, 7'd3, PH_REDA_GRNB}},
    '{ROW_REQ_KNOWN, ADDR_RED, 7'd0, OP_SCAN, MODE_NORMAL,
      '{LAMPS_0, 2'd3, 4'd3, 7'd5, 7'd3, PH_REDA_GRNB}},
    '{ROW_REQ, ADDR_RED, 7'd0, OP_SCAN,   MODE_NORMAL, NO_VIEW},
    '{ROW_REQ, ADDR_RED, 7'd0, OP_SECOND, MODE_RED,    NO_VIEW},
    '{ROW_REQ, ADDR_RED, 7'd0, OP_SECOND, MODE_YELLOW, NO_VIEW},
    '{ROW_REQ, ADDR_RED, 7'd0, OP_SECOND, MODE_GREEN,  NO_VIEW},
    '{ROW_REQ, ADDR_RED, 7'd0, OP_SCAN,   MODE_GREEN,  NO_VIEW},
    '{ROW_REQ, ADDR_RED, 7'd0, OP_SCAN,   MODE_YELLOW, NO_VIEW},
    '{ROW_REQ, ADDR_RED, 7'd0, OP_SCAN,   MODE_RED,    NO_VIEW},
    '{ROW_CFG, ADDR_RED,    7'd127, OP_SECOND, MODE_NORMAL, NO_VIEW},
    '{ROW_CFG, ADDR_YELLOW, 7'd0,   OP_SECOND, MODE_NORMAL, NO_VIEW},
    '{ROW_CFG, ADDR_GREEN,  7'd1,   OP_SECOND, MODE_NORMAL, NO_VIEW},
    '{ROW_REQ, ADDR_RED, 7'd0, OP_SCAN,   MODE_RED,    NO_VIEW},
    '{ROW_REQ, ADDR_RED, 7'd0, OP_SCAN,   MODE_RED,    NO_VIEW},
    '{ROW_REQ_KNOWN, ADDR_RED, 7'd0, OP_SCAN, MODE_RED,
      '{LAMPS_EDITED, 2'd2, 4'd9, 7'd5, 7'd3, PH_REDA_GRNB}},
    '{ROW_REQ, ADDR_RED, 7'd0, OP_SCAN,   MODE_RED,    NO_VIEW},
    '{ROW_REQ, ADDR_RED, 7'd0, OP_SECOND, MODE_NORMAL, NO_VIEW},
    '{ROW_REQ, ADDR_RED, 7'd0, OP_SECOND, MODE_NORMAL, NO_VIEW},
    '{ROW_REQ, ADDR_RED, 7'd0, OP_SECOND, MODE_NORMAL, NO_VIEW},
    '{ROW_REQ, ADDR_RED, 7'd0, OP_SECOND, MODE_NORMAL, NO_VIEW},
    '{ROW_REQ, ADDR_RED, 7'd0, OP_SECOND, MODE_NORMAL, NO_VIEW},
    '{ROW_REQ, ADDR_RED, 7'd0, OP_SCAN,   MODE_NORMAL, NO_VIEW},
    '{ROW_REQ, ADDR_RED, 7'd0, OP_SCAN,   MODE_NORMAL, NO_VIEW},
    '{ROW_REQ, ADDR_RED, 7'd0, OP_SCAN,   MODE_NORMAL, NO_VIEW},
    '{ROW_REQ, ADDR_RED, 7'd0, OP_SECOND, MODE_NORMAL, NO_VIEW},
    '{ROW_REQ, ADDR_RED, 7'd0, OP_SECOND, MODE_NORMAL, NO_VIEW}
  };

  logic                 clk;
  logic                 rst_n;
  logic                 psel;
  logic                 penable;
  logic                 pwrite;
  logic [AddrWidth-1:0] paddr;
  logic [DataWidth-1:0] pwdata;
  logic [DataWidth-1:0] prdata;
  logic                 pready;

  tlc_in_if  in_if ();
  tlc_out_if out_if ();

  two_way_traffic_light_countdown_top dut (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_if   (in_if),
    .out_if  (out_if),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready)
  );

  dur_t                  secs;
  phase_t                phase_now;
  logic [SecWidth-1:0]   cnt_a;
  logic [SecWidth-1:0]   cnt_b;
  logic [1:0]            scan_pos;
  logic [LampWidth-1:0]  lamp_state;
  logic [DigitWidth-1:0] digit_shown;

  light_view_t pending_views [$];
  int          results_seen;
  int          mismatches;
  int          requests_sent;
  int          phase_changes;
  int          cfg_writes;
  int          burst_left;

  function automatic logic [SecWidth-1:0] sat99(input logic [SecWidth-1:0] s);
    return (s > MAX_SECONDS) ? MAX_SECONDS : s;
  endfunction

  function automatic light_view_t light_step(input logic op, input logic [1:0] mode);
    logic [SecWidth-1:0] shown_a;
    logic [SecWidth-1:0] shown_b;
    light_view_t         v;
    if (op == OP_SECOND) begin
      case (mode)
        MODE_NORMAL: begin
          if (cnt_a == '0 || cnt_b == '0) begin
            phase_now = phase_t'(phase_now + 2'd1);
            phase_changes++;
            case (phase_now)
              PH_REDA_GRNB: begin
                lamp_state = LAMP_RED_A | LAMP_GRN_B;
                cnt_a = sat99(secs.red) + 7'd1;
                cnt_b = sat99(secs.green) + 7'd1;
              end
              PH_REDA_YELB: begin
                lamp_state = LAMP_RED_A | LAMP_YEL_B;
                cnt_b = sat99(secs.yellow);
              end
              PH_GRNA_REDB: begin
                lamp_state = LAMP_GRN_A | LAMP_RED_B;
                cnt_a = sat99(secs.green) + 7'd1;
                cnt_b = sat99(secs.red) + 7'd1;
              end
              default: begin
                lamp_state = LAMP_YEL_A | LAMP_RED_B;
                cnt_a = sat99(secs.yellow);
              end
            endcase
          end
          if (cnt_a != '0) cnt_a = cnt_a - 7'd1;
          if (cnt_b != '0) cnt_b = cnt_b - 7'd1;
        end
        MODE_RED:    lamp_state = lamp_state ^ (LAMP_RED_A | LAMP_RED_B);
        MODE_YELLOW: lamp_state = lamp_state ^ (LAMP_YEL_A | LAMP_YEL_B);
        default:     lamp_state = lamp_state ^ (LAMP_GRN_A | LAMP_GRN_B);
      endcase
    end else begin
      if (mode == MODE_NORMAL) begin
        shown_a = cnt_a;
        shown_b = cnt_b;
      end else begin
        shown_a = SecWidth'(mode);
        case (mode)
          MODE_RED:    shown_b = sat99(secs.red);
          MODE_YELLOW: shown_b = sat99(secs.yellow);
          default:     shown_b = sat99(secs.green);
        endcase
      end
      scan_pos = scan_pos + 2'd1;
      case (scan_pos)
        SCAN_A_TENS:  digit_shown = DigitWidth'(int'(shown_a) / DIGIT_BASE);
        SCAN_A_UNITS: digit_shown = DigitWidth'(int'(shown_a) % DIGIT_BASE);
        SCAN_B_TENS:  digit_shown = DigitWidth'(int'(shown_b) / DIGIT_BASE);
        default:      digit_shown = DigitWidth'(int'(shown_b) % DIGIT_BASE);
      endcase
    end
    v.lights = lamp_state;
    v.sel    = scan_pos;
    v.value  = digit_shown;
    v.cnt_a  = cnt_a;
    v.cnt_b  = cnt_b;
    v.phase  = phase_now;
    return v;
  endfunction

  task automatic send_request(input logic op, input logic [1:0] mode, input logic known,
                              input light_view_t want);
    light_view_t predicted;
    @(negedge clk);
    in_if.valid     <= 1'b1;
    in_if.operation <= op;
    in_if.mode      <= mode;
    do @(posedge clk); while (!in_if.ready);
    predicted = light_step(op, mode);
    pending_views.push_back(known ? want : predicted);
    requests_sent++;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 24);
      @(negedge clk);
      in_if.valid <= 1'b0;
      repeat ($urandom_range(1, 8)) @(posedge clk);
    end else begin
      burst_left--;
    end
  endtask

  task automatic park_and_drain();
    @(negedge clk);
    in_if.valid <= 1'b0;
    while (pending_views.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic cfg_write(input logic [AddrWidth-1:0] addr, input logic [SecWidth-1:0] value);
    @(negedge clk);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= addr;
    pwdata  <= DataWidth'(value);
    @(negedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    @(negedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    case (addr)
      ADDR_RED:    secs.red    = value;
      ADDR_YELLOW: secs.yellow = value;
      default:     secs.green  = value;
    endcase
    cfg_writes++;
  endtask

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  initial begin
    #4_000_000;
    $display("timeout with %0d results outstanding", pending_views.size());
    $display("[FAIL] regression broken");
    $finish;
  end

  initial begin
    int hold_left;
    int seg_left;
    int stall_pct;
    int next_hold_at;
    hold_left    = 0;
    seg_left     = 0;
    stall_pct    = 0;
    next_hold_at = 120;
    out_if.ready = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_left == 0 && results_seen >= next_hold_at) begin
        hold_left    = 64;
        next_hold_at = next_hold_at + 300;
      end
      if (hold_left != 0) begin
        hold_left--;
        out_if.ready <= 1'b0;
      end else begin
        if (seg_left == 0) begin
          seg_left = $urandom_range(10, 80);
          case ($urandom_range(0, 3))
            0:       stall_pct = 0;
            1:       stall_pct = 25;
            2:       stall_pct = 50;
            default: stall_pct = 85;
          endcase
        end
        seg_left--;
        out_if.ready <= ($urandom_range(0, 99) >= stall_pct);
      end
    end
  end

  always @(posedge clk) begin
    light_view_t got;
    light_view_t want;
    if (rst_n && out_if.valid && out_if.ready) begin
      got.lights = out_if.lights;
      got.sel    = out_if.digit_select;
      got.value  = out_if.digit_value;
      got.cnt_a  = out_if.count_a;
      got.cnt_b  = out_if.count_b;
      got.phase  = phase_t'(out_if.phase);
      results_seen++;
      if (pending_views.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("unexpected result: lights=%h sel=%0d digit=%0d a=%0d b=%0d phase=%0d",
                   got.lights, got.sel, got.value, got.cnt_a, got.cnt_b, got.phase);
      end else begin
        want = pending_views.pop_front();
        if (got.lights !== want.lights || got.sel !== want.sel || got.value !== want.value ||
            got.cnt_a !== want.cnt_a || got.cnt_b !== want.cnt_b || got.phase !== want.phase) begin
          mismatches++;
          if (mismatches <= 10) begin
            $display("result %0d mismatch", results_seen);
            $display("  expected lights=%h sel=%0d digit=%0d a=%0d b=%0d phase=%0d",
                     want.lights, want.sel, want.value, want.cnt_a, want.cnt_b, want.phase);
            $display("  actual   lights=%h sel=%0d digit=%0d a=%0d b=%0d phase=%0d",
                     got.lights, got.sel, got.value, got.cnt_a, got.cnt_b, got.phase);
          end
        end
      end
    end
  end

  initial begin
    logic [SecWidth-1:0]  value;
    logic [1:0]           cur_mode;
    logic [AddrWidth-1:0] reg_addr [0:2];
    int                   mode_left;
    int                   waited;
    int                   leftover;

    reg_addr[0] = ADDR_RED;
    reg_addr[1] = ADDR_YELLOW;
    reg_addr[2] = ADDR_GREEN;

    rst_n           = 1'b0;
    in_if.valid     = 1'b0;
    in_if.operation = OP_SECOND;
    in_if.mode      = MODE_NORMAL;
    psel            = 1'b0;
    penable         = 1'b0;
    pwrite          = 1'b0;
    paddr           = '0;
    pwdata          = '0;

    secs.red      = RESET_RED;
    secs.yellow   = RESET_YELLOW;
    secs.green    = RESET_GREEN;
    phase_now     = PH_YELA_REDB;
    cnt_a         = '0;
    cnt_b         = '0;
    scan_pos      = '0;
    lamp_state    = '0;
    digit_shown   = '0;
    results_seen  = 0;
    mismatches    = 0;
    requests_sent = 0;
    phase_changes = 0;
    cfg_writes    = 0;
    burst_left    = 0;
    mode_left     = 0;
    cur_mode      = MODE_NORMAL;

    repeat (2) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    for (int i = 0; i < SCRIPT_LEN; i++) begin
      if (SCRIPT[i].kind == ROW_CFG) begin
        park_and_drain();
        cfg_write(SCRIPT[i].addr, SCRIPT[i].secs);
      end else begin
        send_request(SCRIPT[i].op, SCRIPT[i].mode, SCRIPT[i].kind == ROW_REQ_KNOWN,
                     SCRIPT[i].want);
      end
    end

    for (int round = 0; round < ROUNDS; round++) begin
      park_and_drain();
      for (int r = 0; r < 3; r++) begin
        if (round == 0) begin
          value = '0;
        end else if (round == 1) begin
          value = (r == 0) ? 7'h7F : (r == 1) ? MAX_SECONDS : 7'd1;
        end else begin
          case ($urandom_range(0, 9))
            0:       value = '0;
            1:       value = 7'd1;
            2:       value = MAX_SECONDS;
            3:       value = 7'($urandom_range(100, 127));
            default: value = 7'($urandom_range(1, 6));
          endcase
        end
        cfg_write(reg_addr[r], value);
      end
      repeat (ITEMS_PER_ROUND) begin
        if (mode_left == 0) begin
          mode_left = $urandom_range(1, 12);
          cur_mode  = ($urandom_range(0, 9) < 7) ? MODE_NORMAL : 2'($urandom_range(1, 3));
        end
        mode_left--;
        send_request(1'($urandom_range(0, 1)), cur_mode, 1'b0, NO_VIEW);
      end
    end

    @(negedge clk);
    in_if.valid <= 1'b0;
    waited = 0;
    while (pending_views.size() != 0 && waited < DRAIN_LIMIT) begin
      @(posedge clk);
      waited++;
    end
    repeat (8) @(posedge clk);
    leftover = pending_views.size();
    if (leftover != 0)
      $display("%0d expected results never arrived", leftover);

    $display("Ran %0d requests (%0d scripted) across %0d duration writes, %0d phase changes",
             requests_sent, SCRIPT_LEN - 3, cfg_writes, phase_changes);
    $display("Checked %0d results, %0d mismatches", results_seen, mismatches);
    if (mismatches == 0 && leftover == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule
